/* hw/rtl/gbts_pkg.sv */
// types, codes and constants shared by the gap buffer text store
package gbts_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    typedef enum logic [2:0] {
        MODE_INSERT     = 3'd0,
        MODE_BACKSPACE  = 3'd1,
        MODE_LEFT       = 3'd2,
        MODE_RIGHT      = 3'd3,
        MODE_LINE_START = 3'd4,
        MODE_LINE_END   = 3'd5,
        MODE_READ       = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_BOUNDARY = 2'd2,
        ST_OUTSIDE  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_FETCH,
        S_MOVE,
        S_DONE
    } t_state;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] char_in;
        logic [7:0] read_index;
    } t_in;

    typedef struct packed {
        t_status    status;
        logic [7:0] char_out;
        logic [7:0] cursor_pos;
        logic [7:0] text_length;
    } t_out;

endpackage

/* hw/rtl/gap_buffer_text_store.sv */
// gap buffer text store: cursor at gap start, byte store in one synchronous memory
// insert, backspace and refused ops go from the start state straight to the result beat;
// left, right and in-text read pass through the move state; line seeks repeat fetch and
// move per byte carried up to a newline or the text edge (one read, one write per byte)
// one item in flight: the next input beat is taken in the cycle after the result is registered
// reset (synchronous, active low) empties the text; store contents undefined until written
module gap_buffer_text_store #(
    parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  gbts_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output gbts_pkg::t_out  o_out
);

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = AW + 1;
    localparam int LW = (PW > 8) ? PW : 8;
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

    logic [7:0] mem [CAPACITY];

    gbts_pkg::t_state  r_state, n_state;
    logic [PW-1:0]     r_gs, n_gs;
    logic [PW-1:0]     r_ge, n_ge;
    gbts_pkg::t_mode   r_mode;
    logic [7:0]        r_char;
    logic [7:0]        r_idx;
    logic              r_moved, n_moved;
    gbts_pkg::t_status r_status, n_status;
    logic [7:0]        r_rd_char, n_rd_char;
    logic [7:0]        r_rdata;
    logic              r_out_valid;
    gbts_pkg::t_out    r_out;

    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [7:0]        mem_wd;
    logic [AW-1:0]     mem_ra;

    logic [PW-1:0]     gap;
    logic [PW-1:0]     len;
    logic [PW-1:0]     gs_m1;
    logic [PW-1:0]     ge_m1;
    logic [LW-1:0]     phys;
    logic              in_accept;
    logic              out_free;

    assign gap       = r_ge - r_gs;
    assign len       = CAP_P - gap;
    assign gs_m1     = r_gs - PW'(1);
    assign ge_m1     = r_ge - PW'(1);
    assign phys      = (LW'(r_idx) < LW'(r_gs)) ? LW'(r_idx) : LW'(r_idx) + LW'(gap);
    assign o_in_stall = (r_state != gbts_pkg::S_IDLE);
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // read address follows the pointers; data lands in the next cycle
    always_comb begin
        unique case (r_mode) inside
            gbts_pkg::MODE_LEFT, gbts_pkg::MODE_LINE_START: mem_ra = gs_m1[AW-1:0];
            gbts_pkg::MODE_RIGHT, gbts_pkg::MODE_LINE_END:  mem_ra = r_ge[AW-1:0];
            gbts_pkg::MODE_READ:                            mem_ra = phys[AW-1:0];
            default:                                        mem_ra = r_gs[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbts_pkg::S_IDLE;
            r_gs    <= '0;
            r_ge    <= CAP_P;
        end else begin
            r_state <= n_state;
            r_gs    <= n_gs;
            r_ge    <= n_ge;
        end
    end

    always_ff @(posedge i_clk) begin
        r_moved   <= n_moved;
        r_status  <= n_status;
        r_rd_char <= n_rd_char;
        if (in_accept) begin
            r_mode <= i_in.mode;
            r_char <= i_in.char_in;
            r_idx  <= i_in.read_index;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_gs      = r_gs;
        n_ge      = r_ge;
        n_moved   = r_moved;
        n_status  = r_status;
        n_rd_char = r_rd_char;
        mem_we    = 1'b0;
        mem_wa    = r_gs[AW-1:0];
        mem_wd    = r_rdata;
        unique case (r_state)
            gbts_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state   = gbts_pkg::S_START;
                    n_moved   = 1'b0;
                    n_status  = gbts_pkg::ST_DONE;
                    n_rd_char = '0;
                end
            end
            gbts_pkg::S_START: begin
                n_state = gbts_pkg::S_DONE;
                unique case (r_mode) inside
                    gbts_pkg::MODE_INSERT: begin
                        if (gap <= PW'(1)) begin
                            n_status = gbts_pkg::ST_FULL;
                        end else begin
                            mem_we = 1'b1;
                            mem_wa = r_gs[AW-1:0];
                            mem_wd = r_char;
                            n_gs   = r_gs + PW'(1);
                        end
                    end
                    gbts_pkg::MODE_BACKSPACE: begin
                        if (r_gs == '0) begin
                            n_status = gbts_pkg::ST_BOUNDARY;
                        end else begin
                            n_gs = gs_m1;
                        end
                    end
                    gbts_pkg::MODE_LEFT, gbts_pkg::MODE_LINE_START: begin
                        if (r_gs == '0) begin
                            n_status = gbts_pkg::ST_BOUNDARY;
                        end else begin
                            n_state = gbts_pkg::S_MOVE;
                        end
                    end
                    gbts_pkg::MODE_RIGHT, gbts_pkg::MODE_LINE_END: begin
                        if (r_ge == CAP_P) begin
                            n_status = gbts_pkg::ST_BOUNDARY;
                        end else begin
                            n_state = gbts_pkg::S_MOVE;
                        end
                    end
                    gbts_pkg::MODE_READ: begin
                        if (LW'(r_idx) >= LW'(len)) begin
                            n_status = gbts_pkg::ST_OUTSIDE;
                        end else begin
                            n_state = gbts_pkg::S_MOVE;
                        end
                    end
                    default: begin
                        n_status = gbts_pkg::ST_BOUNDARY;
                    end
                endcase
            end
            gbts_pkg::S_FETCH: begin
                n_state = gbts_pkg::S_MOVE;
            end
            gbts_pkg::S_MOVE: begin
                n_state = gbts_pkg::S_DONE;
                unique case (r_mode) inside
                    gbts_pkg::MODE_READ: begin
                        n_rd_char = r_rdata;
                    end
                    gbts_pkg::MODE_LEFT: begin
                        mem_we = 1'b1;
                        mem_wa = ge_m1[AW-1:0];
                        n_gs   = gs_m1;
                        n_ge   = ge_m1;
                    end
                    gbts_pkg::MODE_RIGHT: begin
                        mem_we = 1'b1;
                        mem_wa = r_gs[AW-1:0];
                        n_gs   = r_gs + PW'(1);
                        n_ge   = r_ge + PW'(1);
                    end
                    gbts_pkg::MODE_LINE_START: begin
                        if (r_rdata == gbts_pkg::NEWLINE_BYTE) begin
                            n_status = r_moved ? gbts_pkg::ST_DONE : gbts_pkg::ST_BOUNDARY;
                        end else begin
                            mem_we  = 1'b1;
                            mem_wa  = ge_m1[AW-1:0];
                            n_gs    = gs_m1;
                            n_ge    = ge_m1;
                            n_moved = 1'b1;
                            if (r_gs != PW'(1)) begin
                                n_state = gbts_pkg::S_FETCH;
                            end
                        end
                    end
                    gbts_pkg::MODE_LINE_END: begin
                        if (r_rdata == gbts_pkg::NEWLINE_BYTE) begin
                            n_status = r_moved ? gbts_pkg::ST_DONE : gbts_pkg::ST_BOUNDARY;
                        end else begin
                            mem_we  = 1'b1;
                            mem_wa  = r_gs[AW-1:0];
                            n_gs    = r_gs + PW'(1);
                            n_ge    = r_ge + PW'(1);
                            n_moved = 1'b1;
                            if (r_ge + PW'(1) != CAP_P) begin
                                n_state = gbts_pkg::S_FETCH;
                            end
                        end
                    end
                    default: begin
                        n_status = gbts_pkg::ST_BOUNDARY;
                    end
                endcase
            end
            gbts_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = gbts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gbts_pkg::S_IDLE;
            end
        endcase
    end

    // result beat register
    logic [LW-1:0] gs_ext;
    logic [LW-1:0] len_ext;
    assign gs_ext  = LW'(r_gs);
    assign len_ext = LW'(len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == gbts_pkg::S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gbts_pkg::S_DONE && out_free) begin
            r_out.status      <= r_status;
            r_out.char_out    <= r_rd_char;
            r_out.cursor_pos  <= gs_ext[7:0];
            r_out.text_length <= len_ext[7:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
